// File: hw/rtl/lome_pkg.sv
// shared types and constants of the order matching engine
package lome_pkg;

	localparam int unsigned LOME_ORDERS  = 32;
	localparam int unsigned LOME_CLIENTS = 16;
	localparam int unsigned SLOT_IW      = 6;

	localparam logic CFG_STP_ENABLED = 1'b0;
	localparam logic CFG_STP_POLICY  = 1'b1;

	typedef enum logic [1:0] {
		OP_LIMIT  = 2'd0,
		OP_MARKET = 2'd1,
		OP_CANCEL = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_RESP  = 2'd0,
		KIND_ACC   = 2'd1,
		KIND_TRADE = 2'd2,
		KIND_CXL   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BAD_QTY = 3'd1,
		ST_BAD_PX  = 3'd2,
		ST_DUP_ID  = 3'd3,
		ST_SELF    = 3'd4,
		ST_FULL    = 3'd5,
		ST_UNKNOWN = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_VSCAN,
		S_VDEC,
		S_MSCAN,
		S_MATCH,
		S_CSCAN,
		S_CDEC,
		S_FINAL
	} state_t;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_CLR,
		CMD_SETQ,
		CMD_WRITE
	} cmd_op_t;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        order_id;
		logic [3:0]         owner;
		logic               side;
		logic signed [31:0] price;
		logic [31:0]        quantity;
	} req_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         status;
		logic [31:0]        order_id_res;
		logic [31:0]        buyer_id;
		logic [31:0]        seller_id;
		logic               order_side;
		logic signed [31:0] event_price;
		logic [31:0]        event_quantity;
		logic [31:0]        trade_no;
		logic               resting_removed;
		logic               last;
	} res_t;

	// search key held steady while a scan runs down the row
	typedef struct packed {
		logic               side;
		logic [3:0]         owner;
		logic               has_limit;
		logic signed [31:0] limit;
		logic [31:0]        id;
		logic [31:0]        now;
	} query_t;

	typedef struct packed {
		logic               best_hit;
		logic [SLOT_IW-1:0] best_idx;
		logic signed [31:0] best_price;
		logic [31:0]        best_age;
		logic [31:0]        best_id;
		logic [3:0]         best_owner;
		logic [31:0]        best_qty;
		logic               self_hit;
		logic               free_hit;
		logic [SLOT_IW-1:0] free_idx;
		logic               cxl_hit;
		logic [SLOT_IW-1:0] cxl_idx;
		logic               cxl_side;
		logic signed [31:0] cxl_price;
		logic [31:0]        cxl_qty;
	} scan_t;

	typedef struct packed {
		cmd_op_t            op;
		logic [SLOT_IW-1:0] idx;
		logic [31:0]        id;
		logic [3:0]         owner;
		logic               side;
		logic signed [31:0] price;
		logic [31:0]        qty;
		logic [31:0]        arrival;
	} cmd_t;

endpackage

// File: hw/rtl/lome_cell.sv
// one slot of the order table, a stage of the scan chain
module lome_cell import lome_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  query_t q,
	input  cmd_t   cmd,
	input  scan_t  scan_in,
	output scan_t  scan_out
);

	localparam logic [SLOT_IW-1:0] MY_IDX = SLOT_IW'(IDX);

	logic               valid_q;
	logic [31:0]        id_q;
	logic [3:0]         owner_q;
	logic               side_q;
	logic signed [31:0] price_q;
	logic [31:0]        qty_q;
	logic [31:0]        arr_q;

	scan_t       scan_s1;
	scan_t       s;
	logic        opp;
	logic        crossed;
	logic        better;
	logic [31:0] age;

	always_comb begin
		s       = scan_in;
		opp     = valid_q && (side_q != q.side);
		crossed = !q.has_limit || (q.side == 1'b0 ? (price_q <= q.limit) : (price_q >= q.limit));
		age     = q.now - arr_q;
		if (!scan_in.best_hit) begin
			better = 1'b1;
		end else if (price_q != scan_in.best_price) begin
			better = q.side == 1'b0 ? (price_q < scan_in.best_price)
				: (price_q > scan_in.best_price);
		end else begin
			better = age > scan_in.best_age;
		end
		if (opp && crossed && owner_q == q.owner) begin
			s.self_hit = 1'b1;
		end
		if (opp && better) begin
			s.best_hit   = 1'b1;
			s.best_idx   = MY_IDX;
			s.best_price = price_q;
			s.best_age   = age;
			s.best_id    = id_q;
			s.best_owner = owner_q;
			s.best_qty   = qty_q;
		end
		// lowest free slot and lowest id match win, the chain runs upward
		if (!valid_q && !scan_in.free_hit) begin
			s.free_hit = 1'b1;
			s.free_idx = MY_IDX;
		end
		if (valid_q && id_q == q.id && !scan_in.cxl_hit) begin
			s.cxl_hit   = 1'b1;
			s.cxl_idx   = MY_IDX;
			s.cxl_side  = side_q;
			s.cxl_price = price_q;
			s.cxl_qty   = qty_q;
		end
	end

	always_ff @(posedge clk) begin
		scan_s1 <= s;
	end

	assign scan_out = scan_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.idx == MY_IDX) begin
			case (cmd.op)
				CMD_CLR:   valid_q <= 1'b0;
				CMD_WRITE: valid_q <= 1'b1;
				default:   valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx == MY_IDX) begin
			case (cmd.op)
				CMD_SETQ: begin
					qty_q <= cmd.qty;
				end
				CMD_WRITE: begin
					id_q    <= cmd.id;
					owner_q <= cmd.owner;
					side_q  <= cmd.side;
					price_q <= cmd.price;
					qty_q   <= cmd.qty;
					arr_q   <= cmd.arrival;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hw/rtl/limit_order_matching_engine.sv
// price-time priority order book: request control and the row of slot cells
//
// Requests enter on req (req_valid / req_stall), results leave on res
// (res_valid / res_stall), one transaction per result item. Each request
// gives zero or more events and ends with one response that has last set;
// an opcode of three is taken and gives nothing.
// The book lives in a row of ORDERS cells. Every decision on the book is a
// scan: a search key is held while the running best entry, the lowest free
// slot and the id match ripple through the row, one cell a cycle. A cancel
// takes one scan, a new order one scan for checks and one more per fill or
// self-trade cancel (plus one when it stops without a cross), and the
// engine returns to idle before it takes the next request.
// req_stall stays high until the whole request is done.
// res is a registered stage: a stalled result holds and the engine waits
// on it before producing the next one.
// Reset empties the book, forgets every client id and clears both
// counters; configuration writes on cfg are taken at any time (cfg_ready is
// always high) and are meant for when the engine is idle.
module limit_order_matching_engine import lome_pkg::*; #(
	parameter int unsigned ORDERS  = LOME_ORDERS,
	parameter int unsigned CLIENTS = LOME_CLIENTS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        res_valid,
	input  logic        res_stall,
	output res_t        res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	localparam int unsigned CE   = CLIENTS > 16 ? 16 : CLIENTS;
	localparam int unsigned CIW  = CE > 1 ? $clog2(CE) : 1;
	localparam int unsigned CNTW = $clog2(ORDERS + 1);

	state_t            state_q, state_d;
	logic [CNTW-1:0]   cnt_q;
	req_t              req_q;
	logic [31:0]       rem_q;
	logic [31:0]       arrival_q;
	logic [31:0]       trade_q;
	logic              stp_en_q, stp_pol_q;
	logic              client_seen_q [CE];
	logic [31:0]       client_id_q   [CE];
	res_t              res_q;
	logic              res_valid_q;

	logic [3:0]        own_tab [16];
	logic [3:0]        owner_red;
	req_t              req_in;
	logic [CIW-1:0]    oidx;
	query_t            q;
	scan_t             chain [ORDERS+1];
	scan_t             sr;
	cmd_t              cmd;

	logic              can_emit, scan_done, is_limit, cross_b, stp_cancel;
	status_t           vstat;
	logic [31:0]       fill;
	logic              fill_done;
	logic              emit;
	res_t              emit_res;
	logic              rem_we, trade_inc, arr_inc, client_we;
	logic [31:0]       rem_d;

	always_comb begin
		for (int k = 0; k < 16; k++) begin
			own_tab[k] = 4'(k % CLIENTS);
		end
	end
	assign owner_red = own_tab[req.owner];
	assign oidx      = req_q.owner[CIW-1:0];

	always_comb begin
		req_in       = req;
		req_in.owner = owner_red;
	end

	assign is_limit   = req_q.opcode == OP_LIMIT;
	assign stp_cancel = stp_en_q && stp_pol_q;

	always_comb begin
		q.side      = req_q.side;
		q.owner     = req_q.owner;
		q.has_limit = is_limit;
		q.limit     = req_q.price;
		q.id        = req_q.order_id;
		q.now       = arrival_q;
	end

	assign chain[0] = '0;
	for (genvar i = 0; i < ORDERS; i++) begin : g_cell
		lome_cell #(.IDX(i)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.q        (q),
			.cmd      (cmd),
			.scan_in  (chain[i]),
			.scan_out (chain[i+1])
		);
	end
	assign sr = chain[ORDERS];

	assign can_emit  = !res_valid_q || !res_stall;
	assign scan_done = cnt_q == CNTW'(ORDERS);
	assign cross_b   = sr.best_hit && (!is_limit || (req_q.side == 1'b0
		? (sr.best_price <= req_q.price) : (sr.best_price >= req_q.price)));
	assign fill      = rem_q < sr.best_qty ? rem_q : sr.best_qty;
	assign fill_done = fill == sr.best_qty;

	always_comb begin
		if (req_q.quantity == 32'd0) begin
			vstat = ST_BAD_QTY;
		end else if (is_limit && req_q.price <= 32'sd0) begin
			vstat = ST_BAD_PX;
		end else if (client_seen_q[oidx] && req_q.order_id <= client_id_q[oidx]) begin
			vstat = ST_DUP_ID;
		end else if (stp_en_q && !stp_pol_q && sr.self_hit) begin
			vstat = ST_SELF;
		end else if (is_limit && !sr.free_hit) begin
			vstat = ST_FULL;
		end else begin
			vstat = ST_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req.opcode)
						OP_LIMIT, OP_MARKET: state_d = S_VSCAN;
						OP_CANCEL:           state_d = S_CSCAN;
						default:             state_d = S_IDLE;
					endcase
				end
			end
			S_VSCAN: if (scan_done) state_d = S_VDEC;
			S_VDEC: begin
				if (can_emit) state_d = vstat == ST_OK ? S_MSCAN : S_IDLE;
			end
			S_MSCAN: if (scan_done) state_d = S_MATCH;
			S_MATCH: begin
				if (can_emit) begin
					if (!cross_b) begin
						state_d = S_FINAL;
					end else if (stp_cancel && sr.best_owner == req_q.owner) begin
						state_d = S_MSCAN;
					end else begin
						state_d = rem_q == fill ? S_FINAL : S_MSCAN;
					end
				end
			end
			S_CSCAN: if (scan_done) state_d = S_CDEC;
			S_CDEC: begin
				if (can_emit) state_d = sr.cxl_hit ? S_FINAL : S_IDLE;
			end
			S_FINAL: if (can_emit) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// actions of each state
	always_comb begin
		emit      = 1'b0;
		emit_res  = '0;
		cmd       = '0;
		cmd.op    = CMD_NONE;
		rem_we    = 1'b0;
		rem_d     = rem_q;
		trade_inc = 1'b0;
		arr_inc   = 1'b0;
		client_we = 1'b0;
		case (state_q)
			S_VDEC: begin
				if (can_emit) begin
					emit                  = 1'b1;
					emit_res.order_id_res = req_q.order_id;
					if (vstat != ST_OK) begin
						emit_res.kind   = KIND_RESP;
						emit_res.status = vstat;
						emit_res.last   = 1'b1;
					end else begin
						emit_res.kind           = KIND_ACC;
						emit_res.order_side     = req_q.side;
						emit_res.event_price    = is_limit ? req_q.price : 32'sd0;
						emit_res.event_quantity = req_q.quantity;
						client_we               = 1'b1;
						rem_we                  = 1'b1;
						rem_d                   = req_q.quantity;
					end
				end
			end
			S_MATCH: begin
				if (can_emit) begin
					if (!cross_b) begin
						// no more crossing: a limit remainder rests in the lowest free slot
						if (is_limit && sr.free_hit) begin
							cmd.op      = CMD_WRITE;
							cmd.idx     = sr.free_idx;
							cmd.id      = req_q.order_id;
							cmd.owner   = req_q.owner;
							cmd.side    = req_q.side;
							cmd.price   = req_q.price;
							cmd.qty     = rem_q;
							cmd.arrival = arrival_q;
							arr_inc     = 1'b1;
						end
					end else if (stp_cancel && sr.best_owner == req_q.owner) begin
						emit                    = 1'b1;
						emit_res.kind           = KIND_CXL;
						emit_res.order_id_res   = sr.best_id;
						emit_res.order_side     = !req_q.side;
						emit_res.event_price    = sr.best_price;
						emit_res.event_quantity = sr.best_qty;
						cmd.op                  = CMD_CLR;
						cmd.idx                 = sr.best_idx;
					end else begin
						emit                     = 1'b1;
						emit_res.kind            = KIND_TRADE;
						emit_res.buyer_id        = req_q.side == 1'b0 ? req_q.order_id : sr.best_id;
						emit_res.seller_id       = req_q.side == 1'b1 ? req_q.order_id : sr.best_id;
						emit_res.event_price     = sr.best_price;
						emit_res.event_quantity  = fill;
						emit_res.trade_no        = trade_q;
						emit_res.resting_removed = fill_done;
						cmd.op                   = fill_done ? CMD_CLR : CMD_SETQ;
						cmd.idx                  = sr.best_idx;
						cmd.qty                  = sr.best_qty - fill;
						trade_inc                = 1'b1;
						rem_we                   = 1'b1;
						rem_d                    = rem_q - fill;
					end
				end
			end
			S_CDEC: begin
				if (can_emit) begin
					emit                  = 1'b1;
					emit_res.order_id_res = req_q.order_id;
					if (sr.cxl_hit) begin
						emit_res.kind           = KIND_CXL;
						emit_res.order_side     = sr.cxl_side;
						emit_res.event_price    = sr.cxl_price;
						emit_res.event_quantity = sr.cxl_qty;
						cmd.op                  = CMD_CLR;
						cmd.idx                 = sr.cxl_idx;
						rem_we                  = 1'b1;
						rem_d                   = sr.cxl_qty;
					end else begin
						emit_res.kind   = KIND_RESP;
						emit_res.status = ST_UNKNOWN;
						emit_res.last   = 1'b1;
					end
				end
			end
			S_FINAL: begin
				if (can_emit) begin
					emit                    = 1'b1;
					emit_res.kind           = KIND_RESP;
					emit_res.order_id_res   = req_q.order_id;
					emit_res.event_quantity = rem_q;
					emit_res.last           = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			arrival_q   <= '0;
			trade_q     <= '0;
			stp_en_q    <= 1'b0;
			stp_pol_q   <= 1'b0;
			res_valid_q <= 1'b0;
			for (int k = 0; k < CE; k++) begin
				client_seen_q[k] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			// a scan restarts whenever its state is entered afresh
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if ((state_q == S_VSCAN || state_q == S_MSCAN || state_q == S_CSCAN)
				&& !scan_done) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (arr_inc) arrival_q <= arrival_q + 32'd1;
			if (trade_inc) trade_q <= trade_q + 32'd1;
			if (client_we) client_seen_q[oidx] <= 1'b1;
			if (cfg_valid) begin
				if (cfg_index == CFG_STP_ENABLED) stp_en_q <= cfg_data;
				if (cfg_index == CFG_STP_POLICY) stp_pol_q <= cfg_data;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req_in;
		end
		if (rem_we) rem_q <= rem_d;
		if (client_we) client_id_q[oidx] <= req_q.order_id;
		if (emit) res_q <= emit_res;
	end

	assign req_stall = state_q != S_IDLE;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

	a_match_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MSCAN && scan_done |=> state_q == S_MATCH)
		else $error("match decision not taken after scan completed");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MSCAN |-> rem_q != 32'd0)
		else $error("matching scan with nothing left to fill");

	a_last_is_resp: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> res.kind == KIND_RESP)
		else $error("last flag on an event");

	a_trade_seq: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_res.kind == KIND_TRADE |=> trade_q == $past(trade_q) + 32'd1)
		else $error("trade counter did not advance");

endmodule
